// ===== rtl/dlf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlf_pkg
// shared widths, constants and the side-band record of the dipole force pipe
// ----------------------------------------------------------------------------
package dlf_pkg;

  localparam int unsigned IN_W     = 224;  // seven 32-bit fields
  localparam int unsigned OUT_W    = 144;  // three 48-bit forces
  localparam int unsigned USER_W   = 2;
  localparam int unsigned SQ_STEPS = 32;   // one root bit per stage
  localparam int unsigned DV_STEPS = 34;   // one quotient bit per stage
  localparam int unsigned REM_W    = 36;
  localparam int unsigned SH_W     = 107;

  // 2^58 shifted down by DV_STEPS; the steps bring its low dividend bits back in
  localparam logic [REM_W-1:0] DV_REM0 = REM_W'(64'd1 << (58 - DV_STEPS));
  localparam logic [6:0]       UP_MID  = 7'd82;
  localparam logic [47:0]      LIM_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0]      LIM_NEG = 48'h8000_0000_0000;

  typedef struct packed {
    logic               sx;
    logic               sy;
    logic               sz;
    logic               zge;
    logic               org;
    logic [4:0]         k;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] q;
    logic [31:0]        nx;
    logic [31:0]        ny;
    logic [31:0]        nz;
    logic [33:0]        s4;
  } dlf_side_t;

endpackage
`default_nettype wire

// ===== rtl/dipole_lorentz_force.sv =====
`default_nettype none
// throughput: one word per cycle; the whole pipe advances together and freezes
//   only while a finished result waits on out_tready
// depth is set by the 32-stage square root and the 34-stage reciprocal divider
// reset: synchronous active-low rst_n clears every valid bit; payload is not reset
// ----------------------------------------------------------------------------
// dipole_lorentz_force
// Lorentz force q*(v x B) of a charged particle in a unit dipole field,
// Q16.16 inputs, saturated Q24.24 outputs, fully pipelined
// ----------------------------------------------------------------------------
module dipole_lorentz_force (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, charge
  input  wire logic [dlf_pkg::IN_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // force_x, force_y, force_z
  output logic [dlf_pkg::OUT_W-1:0]        out_tdata,
  // at_origin, clipped
  output logic [dlf_pkg::USER_W-1:0]       out_tuser
);
  import dlf_pkg::*;

  // global advance: everything moves unless a result is stuck at the output
  logic en;
  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: magnitudes, max, origin ----------------
  logic              v1_r;
  logic [31:0]       a1_r [3];
  logic [31:0]       a1_nxt [3];
  logic [31:0]       m1_r, m1_nxt;
  dlf_side_t         sd1_r, sd1_nxt;
  logic [31:0]       pin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pin[i]    = in_tdata[32*i +: 32];
      a1_nxt[i] = pin[i][31] ? (~pin[i] + 32'd1) : pin[i];
    end
    m1_nxt = (a1_nxt[0] > a1_nxt[1]) ? a1_nxt[0] : a1_nxt[1];
    if (a1_nxt[2] > m1_nxt) begin
      m1_nxt = a1_nxt[2];
    end
    sd1_nxt     = '0;
    sd1_nxt.sx  = pin[0][31];
    sd1_nxt.sy  = pin[1][31];
    sd1_nxt.sz  = pin[2][31];
    sd1_nxt.vx  = in_tdata[127:96];
    sd1_nxt.vy  = in_tdata[159:128];
    sd1_nxt.vz  = in_tdata[191:160];
    sd1_nxt.q   = in_tdata[223:192];
    sd1_nxt.org = (in_tdata[95:0] == 96'd0);
  end

  // ---------------- stage 2: normalizing shift k ----------------
  logic              v2_r;
  logic [31:0]       a2_r [3];
  dlf_side_t         sd2_r, sd2_nxt;

  always_comb begin
    sd2_nxt   = sd1_r;
    sd2_nxt.k = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (m1_r[i]) begin
        sd2_nxt.k = 5'(31 - i);
      end
    end
  end

  // ---------------- stage 3: normalized h = (a << k) >> 1 ----------------
  logic              v3_r;
  logic [30:0]       h3_r [3];
  logic [30:0]       h3_nxt [3];
  logic [31:0]       ash [3];
  dlf_side_t         sd3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ash[i]    = a2_r[i] << sd2_r.k;
      h3_nxt[i] = ash[i][31:1];
    end
  end

  // ---------------- stage 4: squares and cross terms ----------------
  logic              v4_r;
  logic [61:0]       sqr4_r [3];
  logic [61:0]       sqr4_nxt [3];
  logic [61:0]       hxz4_r, hyz4_r, hxz4_nxt, hyz4_nxt;
  dlf_side_t         sd4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqr4_nxt[i] = {31'd0, h3_r[i]} * {31'd0, h3_r[i]};
    end
    hxz4_nxt = {31'd0, h3_r[0]} * {31'd0, h3_r[2]};
    hyz4_nxt = {31'd0, h3_r[1]} * {31'd0, h3_r[2]};
  end

  // ---------------- stage 5: r^2 and numerator magnitudes ----------------
  logic              v5_r;
  logic [63:0]       q2_5_r, q2_5_nxt;
  dlf_side_t         sd5_r, sd5_nxt;
  logic [63:0]       t3x, t3y;
  logic [62:0]       tz, txy, dz;

  always_comb begin
    q2_5_nxt = 64'(sqr4_r[0]) + 64'(sqr4_r[1]) + 64'(sqr4_r[2]);
    t3x      = {1'b0, hxz4_r, 1'b0} + 64'(hxz4_r);
    t3y      = {1'b0, hyz4_r, 1'b0} + 64'(hyz4_r);
    tz       = {sqr4_r[2], 1'b0};
    txy      = 63'(sqr4_r[0]) + 63'(sqr4_r[1]);
    sd5_nxt     = sd4_r;
    sd5_nxt.zge = (tz >= txy);
    dz          = sd5_nxt.zge ? (tz - txy) : (txy - tz);
    sd5_nxt.nx  = t3x[63:32];
    sd5_nxt.ny  = t3y[63:32];
    sd5_nxt.nz  = {1'b0, dz[62:32]};
  end

  // ---------------- square root: stage 0 loads, one root bit per stage ----------------
  logic              sq_v_r   [SQ_STEPS+1];
  logic [63:0]       sq_n_r   [SQ_STEPS+1];
  logic [63:0]       sq_res_r [SQ_STEPS+1];
  dlf_side_t         sq_sd_r  [SQ_STEPS+1];
  logic [63:0]       sq_n_nxt   [SQ_STEPS+1];
  logic [63:0]       sq_res_nxt [SQ_STEPS+1];
  dlf_side_t         sq_sd_nxt  [SQ_STEPS+1];
  logic [63:0]       s2sq;
  logic [63:0]       sq_bit [SQ_STEPS];
  logic [63:0]       sq_try [SQ_STEPS];

  always_comb begin
    s2sq             = {32'd0, q2_5_r[63:32]} * {32'd0, q2_5_r[63:32]};
    sq_n_nxt[0]      = q2_5_r;
    sq_res_nxt[0]    = '0;
    sq_sd_nxt[0]     = sd5_r;
    sq_sd_nxt[0].s4  = s2sq[63:30];
    for (int i = 0; i < SQ_STEPS; i++) begin
      sq_bit[i]       = 64'd1 << (62 - 2 * i);
      sq_try[i]       = sq_res_r[i] + sq_bit[i];
      sq_sd_nxt[i+1]  = sq_sd_r[i];
      if (sq_n_r[i] >= sq_try[i]) begin
        sq_n_nxt[i+1]   = sq_n_r[i] - sq_try[i];
        sq_res_nxt[i+1] = (sq_res_r[i] >> 1) + sq_bit[i];
      end else begin
        sq_n_nxt[i+1]   = sq_n_r[i];
        sq_res_nxt[i+1] = sq_res_r[i] >> 1;
      end
    end
  end

  // ---------------- reciprocal 2^58 / r5: stage 0 forms r5 ----------------
  logic              dv_v_r   [DV_STEPS+1];
  logic [REM_W-1:0]  dv_rem_r [DV_STEPS+1];
  logic [33:0]       dv_d_r   [DV_STEPS+1];
  logic [33:0]       dv_q_r   [DV_STEPS+1];
  dlf_side_t         dv_sd_r  [DV_STEPS+1];
  logic [REM_W-1:0]  dv_rem_nxt [DV_STEPS+1];
  logic [33:0]       dv_d_nxt   [DV_STEPS+1];
  logic [33:0]       dv_q_nxt   [DV_STEPS+1];
  logic [64:0]       r5p;
  logic [REM_W-1:0]  dv_sh [DV_STEPS];

  always_comb begin
    r5p            = {31'd0, sq_sd_r[SQ_STEPS].s4} * {34'd0, sq_res_r[SQ_STEPS][31:1]};
    dv_d_nxt[0]    = (r5p[63:30] == 34'd0) ? 34'd1 : r5p[63:30];
    dv_rem_nxt[0]  = DV_REM0;
    dv_q_nxt[0]    = '0;
    for (int j = 0; j < DV_STEPS; j++) begin
      dv_sh[j]      = {dv_rem_r[j][REM_W-2:0], 1'b0};
      dv_d_nxt[j+1] = dv_d_r[j];
      if (dv_sh[j] >= {2'b00, dv_d_r[j]}) begin
        dv_rem_nxt[j+1] = dv_sh[j] - {2'b00, dv_d_r[j]};
        dv_q_nxt[j+1]   = {dv_q_r[j][32:0], 1'b1};
      end else begin
        dv_rem_nxt[j+1] = dv_sh[j];
        dv_q_nxt[j+1]   = {dv_q_r[j][32:0], 1'b0};
      end
    end
  end

  // ---------------- stage B: signed field components ----------------
  logic               vb_r;
  logic signed [32:0] b_r [3];
  logic signed [32:0] b_nxt [3];
  logic [65:0]        bp [3];
  logic [31:0]        bm [3];
  logic [31:0]        nsel [3];
  dlf_side_t          sdb_r;

  always_comb begin
    nsel[0] = dv_sd_r[DV_STEPS].nx;
    nsel[1] = dv_sd_r[DV_STEPS].ny;
    nsel[2] = dv_sd_r[DV_STEPS].nz;
    for (int i = 0; i < 3; i++) begin
      bp[i] = {34'd0, nsel[i]} * {32'd0, dv_q_r[DV_STEPS]};
      bm[i] = bp[i][63:32];
    end
    b_nxt[0] = (dv_sd_r[DV_STEPS].sx ^ dv_sd_r[DV_STEPS].sz) ?
               $signed({1'b0, bm[0]}) : -$signed({1'b0, bm[0]});
    b_nxt[1] = (dv_sd_r[DV_STEPS].sy ^ dv_sd_r[DV_STEPS].sz) ?
               $signed({1'b0, bm[1]}) : -$signed({1'b0, bm[1]});
    b_nxt[2] = dv_sd_r[DV_STEPS].zge ?
               -$signed({1'b0, bm[2]}) : $signed({1'b0, bm[2]});
  end

  // ---------------- stage C: cross product terms ----------------
  logic               vc_r;
  logic signed [64:0] pr_r [6];
  logic signed [64:0] pr_nxt [6];
  dlf_side_t          sdc_r;

  always_comb begin
    pr_nxt[0] = 65'(sdb_r.vy) * 65'(b_r[2]);
    pr_nxt[1] = 65'(sdb_r.vz) * 65'(b_r[1]);
    pr_nxt[2] = 65'(sdb_r.vz) * 65'(b_r[0]);
    pr_nxt[3] = 65'(sdb_r.vx) * 65'(b_r[2]);
    pr_nxt[4] = 65'(sdb_r.vx) * 65'(b_r[1]);
    pr_nxt[5] = 65'(sdb_r.vy) * 65'(b_r[0]);
  end

  // ---------------- stage D: v x B ----------------
  logic               vd_r;
  logic signed [63:0] m_r [3];
  logic signed [63:0] m_nxt [3];
  dlf_side_t          sdd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_nxt[i] = 64'(pr_r[2*i] - pr_r[2*i+1]);
    end
  end

  // ---------------- stage E: q * |M| partial products ----------------
  logic               ve_r;
  logic [63:0]        pl_r [3], ph_r [3];
  logic [63:0]        pl_nxt [3], ph_nxt [3];
  logic               neg_e_r [3], neg_e_nxt [3];
  logic [63:0]        am [3];
  logic [31:0]        aq;
  dlf_side_t          sde_r;

  always_comb begin
    aq = sdd_r.q[31] ? (~sdd_r.q + 32'd1) : sdd_r.q;
    for (int i = 0; i < 3; i++) begin
      am[i]        = m_r[i][63] ? (~m_r[i] + 64'd1) : m_r[i];
      neg_e_nxt[i] = sdd_r.q[31] ^ m_r[i][63];
      pl_nxt[i]    = {32'd0, aq} * {32'd0, am[i][31:0]};
      ph_nxt[i]    = {32'd0, aq} * {32'd0, am[i][63:32]};
    end
  end

  // ---------------- stage F: full product ----------------
  logic               vf_r;
  logic [95:0]        p_r [3], p_nxt [3];
  logic               neg_f_r [3];
  dlf_side_t          sdf_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = {32'd0, pl_r[i]} + {ph_r[i], 32'd0};
    end
  end

  // ---------------- stage G: scale by 2^(3k-82) ----------------
  logic               vg_r;
  logic [SH_W-1:0]    w_r [3], w_nxt [3];
  logic               neg_g_r [3];
  logic [6:0]         up;
  dlf_side_t          sdg_r;

  always_comb begin
    up = {2'b00, sdf_r.k} + {1'b0, sdf_r.k, 1'b0};
    for (int i = 0; i < 3; i++) begin
      if (up < UP_MID) begin
        w_nxt[i] = {11'd0, p_r[i]} >> (UP_MID - up);
      end else begin
        w_nxt[i] = {11'd0, p_r[i]} << (up - UP_MID);
      end
    end
  end

  // ---------------- stage H: saturate, sign, output register ----------------
  logic [OUT_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic [USER_W-1:0]  out_tuser_r, out_tuser_nxt;
  logic [47:0]        lim [3], mag [3];
  logic               clp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i] = neg_g_r[i] ? LIM_NEG : LIM_POS;
      clp[i] = (w_r[i] > {59'd0, lim[i]});
      mag[i] = clp[i] ? lim[i] : w_r[i][47:0];
      out_tdata_nxt[48*i +: 48] = sdg_r.org ? 48'd0 :
                                  (neg_g_r[i] ? (~mag[i] + 48'd1) : mag[i]);
    end
    out_tuser_nxt[0] = sdg_r.org;
    out_tuser_nxt[1] = !sdg_r.org && (clp[0] || clp[1] || clp[2]);
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      for (int i = 0; i <= SQ_STEPS; i++) begin
        sq_v_r[i] <= 1'b0;
      end
      for (int j = 0; j <= DV_STEPS; j++) begin
        dv_v_r[j] <= 1'b0;
      end
      vb_r         <= 1'b0;
      vc_r         <= 1'b0;
      vd_r         <= 1'b0;
      ve_r         <= 1'b0;
      vf_r         <= 1'b0;
      vg_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r      <= in_tvalid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      sq_v_r[0] <= v5_r;
      for (int i = 0; i < SQ_STEPS; i++) begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
      for (int j = 0; j < DV_STEPS; j++) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      vb_r         <= dv_v_r[DV_STEPS];
      vc_r         <= vb_r;
      vd_r         <= vc_r;
      ve_r         <= vd_r;
      vf_r         <= ve_r;
      vg_r         <= vf_r;
      out_tvalid_r <= vg_r;
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= a1_nxt;
      m1_r  <= m1_nxt;
      sd1_r <= sd1_nxt;
      a2_r  <= a1_r;
      sd2_r <= sd2_nxt;
      h3_r  <= h3_nxt;
      sd3_r <= sd2_r;
      sqr4_r <= sqr4_nxt;
      hxz4_r <= hxz4_nxt;
      hyz4_r <= hyz4_nxt;
      sd4_r  <= sd3_r;
      q2_5_r <= q2_5_nxt;
      sd5_r  <= sd5_nxt;
      for (int i = 0; i <= SQ_STEPS; i++) begin
        sq_n_r[i]   <= sq_n_nxt[i];
        sq_res_r[i] <= sq_res_nxt[i];
        sq_sd_r[i]  <= sq_sd_nxt[i];
      end
      for (int j = 0; j <= DV_STEPS; j++) begin
        dv_rem_r[j] <= dv_rem_nxt[j];
        dv_d_r[j]   <= dv_d_nxt[j];
        dv_q_r[j]   <= dv_q_nxt[j];
      end
      dv_sd_r[0] <= sq_sd_r[SQ_STEPS];
      for (int j = 0; j < DV_STEPS; j++) begin
        dv_sd_r[j+1] <= dv_sd_r[j];
      end
      b_r     <= b_nxt;
      sdb_r   <= dv_sd_r[DV_STEPS];
      pr_r    <= pr_nxt;
      sdc_r   <= sdb_r;
      m_r     <= m_nxt;
      sdd_r   <= sdc_r;
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      neg_e_r <= neg_e_nxt;
      sde_r   <= sdd_r;
      p_r     <= p_nxt;
      neg_f_r <= neg_e_r;
      sdf_r   <= sde_r;
      w_r     <= w_nxt;
      neg_g_r <= neg_f_r;
      sdg_r   <= sdf_r;
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- checks ----------------
  // a particle at the origin carries no force and no saturation
  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("origin word with nonzero force or clip");

  // a clipped word has at least one component pinned at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (out_tdata[47:0] == LIM_POS) || (out_tdata[47:0] == LIM_NEG) ||
      (out_tdata[95:48] == LIM_POS) || (out_tdata[95:48] == LIM_NEG) ||
      (out_tdata[143:96] == LIM_POS) || (out_tdata[143:96] == LIM_NEG))
    else $error("clip flag without a saturated component");

  // divider starts with the high dividend bits already reduced: needs r5 above them
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[0] && !dv_sd_r[0].org |-> ({2'b00, dv_d_r[0]} > DV_REM0))
    else $error("r5 below divider start remainder");

endmodule
`default_nettype wire
